>>> rtl/core/first_fit_row_seat_allocator_macros.svh
// Assertion helpers used by the checker file.
// Both macros sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef FIRST_FIT_ROW_SEAT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_ROW_SEAT_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFRSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define FFRSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

`endif

>>> rtl/core/ffrsa_pkg.sv
`timescale 1ns / 1ps

package ffrsa_pkg;

  // Field widths.
  localparam int ROW_W        = 6;
  localparam int SEAT_BITS    = 12;
  localparam int WANT_W       = 18;
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_ROWS_DEF = 64;

  // Register reset values.
  localparam logic [CFG_W-1:0] SEATS_PER_ROW_RST = CFG_W'(16);
  localparam logic [CFG_W-1:0] ROWS_IN_USE_RST   = CFG_W'(64);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEATS_PER_ROW = 2'd0,
    CFG_ROWS_IN_USE   = 2'd1
  } cfg_idx_t;

  // Request kinds.
  localparam logic KIND_CONTIG  = 1'b0;
  localparam logic KIND_SCATTER = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [WANT_W-1:0] seats_wanted;
    logic [ROW_W-1:0]  max_row;
  } in_beat_t;

  typedef struct packed {
    logic                 granted;
    logic [ROW_W-1:0]     row_index;
    logic [SEAT_BITS-1:0] first_seat;
  } out_beat_t;

  // Token that walks the row cells, one cell per cycle.
  typedef struct packed {
    logic                 vld;
    logic                 kind;
    logic                 commit;   // cells may book seats on this pass
    logic                 hit;      // contiguous request already placed
    logic [ROW_W-1:0]     last;     // highest row the request may use
    logic [WANT_W-1:0]    rem;      // seats still to be found
    logic [ROW_W-1:0]     row;
    logic [SEAT_BITS-1:0] seat;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PUSH
  } ctrl_state_t;

endpackage

>>> rtl/core/first_fit_row_seat_allocator.sv
`timescale 1ns / 1ps
// First-fit row seat allocator.
// Requests arrive on the in_ channel (valid/ready) and each one yields exactly one
// result beat on the out_ channel (valid/ready). A contiguous request books adjacent
// seats in the lowest row that still has room; a scattered request books seats across
// rows from the lowest upward once the rows in range are known to hold enough.
// Each row is a cell of a chain holding its fill count; a token walks the chain one
// row per cycle. A contiguous request is served by one pass over the chain; a
// scattered one by a check pass, then, if the rows hold enough, a booking pass.
// One request is in flight at a time; a new request is taken the cycle after the
// previous result is loaded into the output register.
// The result sits in an output register; if the receiver stalls, the next request is
// still accepted and worked, and its result waits in the sequencer until the output
// register frees up.
// Synchronous reset empties every row, sets seats_per_row to 16 and rows_in_use to 64.
// The cfg_ port writes seats_per_row (index 0) or rows_in_use (index 1); the user
// must write them only while idle, as the block itself does not enforce this.

module first_fit_row_seat_allocator
  import ffrsa_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] spr_r, spr_nxt;
  logic [CFG_W-1:0] riu_r, riu_nxt;
  tok_t             chain [MAX_ROWS+1];

  // Configuration registers; writes beyond the list are dropped.
  always_comb begin
    spr_nxt = spr_r;
    riu_nxt = riu_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEATS_PER_ROW: spr_nxt = cfg_data;
        CFG_ROWS_IN_USE:   riu_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r <= SEATS_PER_ROW_RST;
      riu_r <= ROWS_IN_USE_RST;
    end else begin
      spr_r <= spr_nxt;
      riu_r <= riu_nxt;
    end
  end

  // Request sequencer and result register.
  ffrsa_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .rows_in_use (riu_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .launch      (chain[0]),
    .ret         (chain[MAX_ROWS])
  );

  // One cell per row, token handed along each cycle.
  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_row
    ffrsa_cell #(
      .ROW_IDX (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .seats_per_row (spr_r[SEAT_BITS-1:0]),
      .tok_i         (chain[g]),
      .tok_o         (chain[g+1])
    );
  end

endmodule

>>> rtl/core/ffrsa_cell.sv
`timescale 1ns / 1ps

module ffrsa_cell
  import ffrsa_pkg::*;
#(
  parameter int ROW_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [SEAT_BITS-1:0] seats_per_row,
  input  tok_t                 tok_i,
  output tok_t                 tok_o
);

  localparam logic [ROW_W-1:0] ROW_CODE = ROW_W'(ROW_IDX);

  logic [SEAT_BITS-1:0] fill_r, fill_nxt;
  tok_t                 tok_r, tok_nxt;
  logic [SEAT_BITS-1:0] free_seats;
  logic [WANT_W-1:0]    free_w;
  logic [WANT_W-1:0]    take;
  logic                 in_range;

  // Free seats of this row; an overfull row has none.
  always_comb begin
    free_seats = (fill_r >= seats_per_row) ? '0 : (seats_per_row - fill_r);
    free_w     = WANT_W'(free_seats);
    take       = (free_w < tok_i.rem) ? free_w : tok_i.rem;
    in_range   = tok_i.vld && (int'(tok_i.last) >= ROW_IDX);
  end

  // Serve the passing token and hand it on.
  always_comb begin
    tok_nxt  = tok_i;
    fill_nxt = fill_r;
    if (in_range) begin
      if (tok_i.kind == KIND_CONTIG) begin
        if (!tok_i.hit && (free_w >= tok_i.rem)) begin
          tok_nxt.hit  = 1'b1;
          tok_nxt.row  = ROW_CODE;
          tok_nxt.seat = fill_r;
          fill_nxt     = fill_r + SEAT_BITS'(tok_i.rem);
        end
      end else begin
        tok_nxt.rem = tok_i.rem - take;
        if (tok_i.commit) begin
          fill_nxt = fill_r + SEAT_BITS'(take);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      tok_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

>>> rtl/core/ffrsa_ctrl.sv
`timescale 1ns / 1ps

module ffrsa_ctrl
  import ffrsa_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] rows_in_use,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data,
  output tok_t             launch,
  input  tok_t             ret
);

  localparam int CLOG_ROWS = $clog2(MAX_ROWS + 1);
  localparam int CNT_W     = (CLOG_ROWS > CFG_W) ? CLOG_ROWS : CFG_W;
  localparam logic [CNT_W-1:0] ROWS_CAP = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

  ctrl_state_t       state_r, state_nxt;
  logic [WANT_W-1:0] want_r, want_nxt;
  logic [ROW_W-1:0]  last_r, last_nxt;
  out_beat_t         res_r, res_nxt;
  out_beat_t         out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;
  tok_t              launch_r, launch_nxt;

  logic [CNT_W-1:0] riu_w, active, top_row, mr_w, last_w;
  logic [ROW_W-1:0] last_in;

  // Clamp the request's row limit to the rows in use.
  always_comb begin
    riu_w   = CNT_W'(rows_in_use);
    active  = (riu_w == '0) ? ONE : ((riu_w > ROWS_CAP) ? ROWS_CAP : riu_w);
    top_row = active - ONE;
    mr_w    = CNT_W'(in_data.max_row);
    last_w  = (mr_w > top_row) ? top_row : mr_w;
    last_in = last_w[ROW_W-1:0];
  end

  // Sequencer: launch passes, collect the returning token, hand off the result.
  always_comb begin
    state_nxt   = state_r;
    want_nxt    = want_r;
    last_nxt    = last_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    launch_nxt  = '0;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          want_nxt          = in_data.seats_wanted;
          last_nxt          = last_in;
          launch_nxt.vld    = 1'b1;
          launch_nxt.kind   = in_data.kind;
          launch_nxt.commit = (in_data.kind == KIND_CONTIG);
          launch_nxt.last   = last_in;
          launch_nxt.rem    = in_data.seats_wanted;
          state_nxt         = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ret.vld) begin
          if (ret.kind == KIND_CONTIG) begin
            res_nxt.granted    = ret.hit;
            res_nxt.row_index  = ret.row;
            res_nxt.first_seat = ret.seat;
            state_nxt          = ST_PUSH;
          end else if (!ret.commit && (ret.rem == '0)) begin
            // Enough free seats in range: book them on a second pass.
            launch_nxt.vld    = 1'b1;
            launch_nxt.kind   = KIND_SCATTER;
            launch_nxt.commit = 1'b1;
            launch_nxt.last   = last_r;
            launch_nxt.rem    = want_r;
          end else begin
            res_nxt         = '0;
            res_nxt.granted = ret.commit;
            state_nxt       = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (!out_vld_r || out_ready) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      launch_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      launch_r  <= launch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    want_r <= want_nxt;
    last_r <= last_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign launch    = launch_r;

endmodule

>>> rtl/core/ffrsa_chk.sv
`timescale 1ns / 1ps
`include "first_fit_row_seat_allocator_macros.svh"

module ffrsa_chk
  import ffrsa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // A stalled result beat stays put.
  `FFRSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // A refused request reports neither row nor seat.
  `FFRSA_ASSERT_SAME(a_refuse_zero, out_valid && !out_data.granted,
                     out_data.row_index == '0 && out_data.first_seat == '0)

  // Only one request is worked at a time.
  `FFRSA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A result never appears right after a request is taken.
  `FFRSA_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

endmodule

bind first_fit_row_seat_allocator ffrsa_chk u_chk (.*);
